### design/mtd_pkg.sv
package mtd_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_B64  = 2'd1;
  localparam logic [1:0] MODE_QP   = 2'd2;

  localparam logic CFG_DECODE_MODE = 1'b0;
  localparam logic CFG_STRIP_CR    = 1'b1;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_EQ = 8'h3D;

  localparam logic [6:0] B64_PAD   = 7'd64;
  localparam logic [6:0] B64_OTHER = 7'd65;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [2:0]      bad;
    logic [1:0]      cnt;
  } entry_t;

  function automatic logic [6:0] b64_value(input logic [7:0] c);
    logic [6:0] v;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = 7'(c - 8'h47);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 7'(c + 8'h04);
    end else if (c == 8'h2B) begin
      v = 7'd62;
    end else if (c == 8'h2F) begin
      v = 7'd63;
    end else if (c == CHAR_EQ) begin
      v = B64_PAD;
    end else begin
      v = B64_OTHER;
    end
    return v;
  endfunction

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] h;
    if (c >= 8'h30 && c <= 8'h39) begin
      h = 5'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h = 5'(c - 8'h37);
    end else begin
      h = 5'd16;
    end
    return h;
  endfunction

endpackage

### design/mime_transfer_decoder_core.sv
// The decoded bytes of an accepted request are written into the entry queue, then the entry is
// loaded into the output stage's current-entry register, from which out_* presents them.
// Throughput: one request per cycle unless the queue is full; one decoded byte per cycle on the
// output side while out_tready is high. A request that yields several bytes holds the output
// until all are taken; the queue absorbs the burst, and in_tready drops only while it is full.
// Reset (rst_n low, synchronous): mode pass-through, strip off, decoder state and queue cleared.
module mime_transfer_decoder_core #(
  parameter int unsigned QUEUE_DEPTH = mtd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tuser,  // [0] bad_digit
  output logic        out_tlast
);

  logic            q_full, q_push, q_pop, q_head_valid;
  mtd_pkg::entry_t q_entry, q_head;

  mtd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  mtd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_entry (q_head)
  );

  mtd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_entry (q_head),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### design/mtd_front.sv
module mtd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_index,
  input  logic [1:0]        cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              in_tlast,
  input  logic              q_full,
  output logic              q_push,
  output mtd_pkg::entry_t   q_entry
);

  typedef enum logic [1:0] {PH_IDLE, PH_EQ, PH_DIGIT, PH_CR} phase_t;

  logic [1:0]  mode_r;
  logic        strip_r;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [17:0] store_r, store_nxt;
  phase_t      phase_r, phase_nxt;
  logic [3:0]  hi_r, hi_nxt;
  logic        err_r, err_nxt;

  logic [6:0]  v;
  logic        letter, ins, e3, ep, flush;
  logic [17:0] st_ins;
  logic [1:0]  cnt_ins;
  logic [5:0]  s3;
  logic [4:0]  h;
  logic        hok;
  logic [3:0]  hval;
  logic        accept;

  logic [2:0][7:0] cand;
  logic [2:0]      cand_bad;
  logic [1:0]      cand_n;
  logic [1:0]      k;
  mtd_pkg::entry_t ent;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    v      = mtd_pkg::b64_value(in_tdata);
    letter = !v[6];
    ins    = letter && (cnt_r != 2'd3);
    st_ins = store_r;
    if (ins) begin
      case (cnt_r)
        2'd0:    st_ins = store_r | {v[5:0], 12'b0};
        2'd1:    st_ins = store_r | {6'b0, v[5:0], 6'b0};
        default: st_ins = store_r | {12'b0, v[5:0]};
      endcase
    end
    cnt_ins = ins ? cnt_r + 2'd1 : cnt_r;
    e3      = letter && (cnt_r == 2'd3);
    ep      = (v == mtd_pkg::B64_PAD) && (cnt_r != 2'd0);
    flush   = in_tlast && !e3 && !ep && (cnt_ins != 2'd0);
    s3      = e3 ? v[5:0] : 6'b0;

    h    = mtd_pkg::hex_value(in_tdata);
    hok  = !h[4];
    hval = hok ? h[3:0] : 4'h0;

    cand      = '0;
    cand_bad  = '0;
    cand_n    = 2'd0;
    cnt_nxt   = cnt_r;
    store_nxt = store_r;
    phase_nxt = phase_r;
    hi_nxt    = hi_r;
    err_nxt   = err_r;

    unique case (mode_r)
      mtd_pkg::MODE_B64: begin
        cand[0] = {st_ins[17:12], st_ins[11:10]};
        cand[1] = {st_ins[9:6], st_ins[5:2]};
        cand[2] = {st_ins[1:0], s3};
        if (e3) begin
          cand_n = 2'd3;
        end else if (ep) begin
          cand_n = (cnt_r == 2'd3) ? 2'd2 : 2'd1;
        end else if (flush) begin
          cand_n = (cnt_ins == 2'd3) ? 2'd2 : 2'd1;
        end
        if (e3 || ep) begin
          cnt_nxt   = 2'd0;
          store_nxt = '0;
        end else begin
          cnt_nxt   = cnt_ins;
          store_nxt = st_ins;
        end
      end
      mtd_pkg::MODE_QP: begin
        unique case (phase_r)
          PH_IDLE: begin
            if (in_tdata == mtd_pkg::CHAR_EQ) begin
              phase_nxt = PH_EQ;
            end else begin
              cand[0] = in_tdata;
              cand_n  = 2'd1;
            end
          end
          PH_EQ: begin
            if (in_tdata == mtd_pkg::CHAR_CR) begin
              phase_nxt = PH_CR;
            end else if (in_tdata == mtd_pkg::CHAR_LF) begin
              phase_nxt = PH_IDLE;
            end else begin
              hi_nxt    = hval;
              err_nxt   = !hok;
              phase_nxt = PH_DIGIT;
              if (in_tlast) begin
                cand[0]     = {hval, 4'h0};
                cand_bad[0] = 1'b1;
                cand_n      = 2'd1;
              end
            end
          end
          PH_DIGIT: begin
            cand[0]     = {hi_r, hval};
            cand_bad[0] = err_r || !hok;
            cand_n      = 2'd1;
            phase_nxt   = PH_IDLE;
            hi_nxt      = 4'h0;
            err_nxt     = 1'b0;
          end
          PH_CR: begin
            phase_nxt = PH_IDLE;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
      default: begin
        cand[0] = in_tdata;
        cand_n  = 2'd1;
      end
    endcase

    ent = '0;
    k   = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if ((2'(i) < cand_n) && !(strip_r && cand[i] == mtd_pkg::CHAR_CR)) begin
        ent.bytes[k] = cand[i];
        ent.bad[k]   = cand_bad[i];
        k            = k + 2'd1;
      end
    end
    ent.cnt = k;
  end

  assign q_push  = accept && (k != 2'd0);
  assign q_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= mtd_pkg::MODE_PASS;
      strip_r <= 1'b0;
      cnt_r   <= 2'd0;
      store_r <= '0;
      phase_r <= PH_IDLE;
      hi_r    <= 4'h0;
      err_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      if (cfg_index == mtd_pkg::CFG_DECODE_MODE) begin
        mode_r  <= cfg_wdata;
        cnt_r   <= 2'd0;
        store_r <= '0;
        phase_r <= PH_IDLE;
        hi_r    <= 4'h0;
        err_r   <= 1'b0;
      end else begin
        strip_r <= cfg_wdata[0];
      end
    end else if (accept) begin
      if (in_tlast) begin
        cnt_r   <= 2'd0;
        store_r <= '0;
        phase_r <= PH_IDLE;
        hi_r    <= 4'h0;
        err_r   <= 1'b0;
      end else begin
        cnt_r   <= cnt_nxt;
        store_r <= store_nxt;
        phase_r <= phase_nxt;
        hi_r    <= hi_nxt;
        err_r   <= err_nxt;
      end
    end
  end

endmodule

### design/mtd_queue.sv
module mtd_queue #(
  parameter int unsigned DEPTH = mtd_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mtd_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output mtd_pkg::entry_t head_entry
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mtd_pkg::entry_t mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

### design/mtd_back.sv
module mtd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  mtd_pkg::entry_t head_entry,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [7:0]      out_tdata,
  output logic            out_tuser,
  output logic            out_tlast
);

  mtd_pkg::entry_t cur_r;
  logic            cur_valid_r;
  logic [1:0]      idx_r;
  logic            is_last, adv, done;

  assign is_last = (idx_r == cur_r.cnt - 2'd1);
  assign adv     = cur_valid_r && out_tready;
  assign done    = adv && is_last;
  assign pop     = head_valid && (!cur_valid_r || done);

  assign out_tvalid = cur_valid_r;
  assign out_tdata  = cur_r.bytes[idx_r];
  assign out_tuser  = cur_r.bad[idx_r];
  assign out_tlast  = is_last;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (pop) begin
      cur_valid_r <= 1'b1;
      idx_r       <= 2'd0;
    end else if (done) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (adv) begin
      idx_r <= idx_r + 2'd1;
    end
  end

endmodule

### dv/mime_transfer_decoder_core_tb.sv
module mime_transfer_decoder_core_tb;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam string HEX_CHARS = "0123456789ABCDEF";
  localparam string B64_CHARS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/=";

  typedef enum logic [1:0] {
    ESC_NONE,
    ESC_AFTER_EQ,
    ESC_AFTER_DIGIT,
    ESC_SOFT_CR
  } esc_e;

  typedef struct packed {
    logic [7:0] data;
    logic       bad;
    logic       last;
  } decoded_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = 1'b0;
  logic [1:0]  cfg_wdata = 2'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;   // [7:0] in_byte
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // [7:0] out_byte
  logic        out_tuser;         // [0] bad_digit
  logic        out_tlast;

  logic [1:0]  mode_q = mtd_pkg::MODE_PASS;
  logic        strip_q = 1'b0;
  logic [1:0]  grp_cnt = 2'd0;
  logic [17:0] sextets = 18'd0;
  esc_e        esc = ESC_NONE;
  logic [3:0]  hi_nib = 4'd0;
  logic        nib_bad = 1'b0;

  decoded_t    step_q[$];
  decoded_t    expected_q[$];
  int          errors = 0;
  int          sent_count = 0;
  int          quiet_cycles = 0;
  int          ready_hold = 0;
  bit          gaps_on = 1'b1;

  mime_transfer_decoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void clear_state();
    grp_cnt = 2'd0;
    sextets = 18'd0;
    esc = ESC_NONE;
    hi_nib = 4'd0;
    nib_bad = 1'b0;
  endfunction

  function automatic void push_byte(logic [7:0] b, logic bad);
    if (!(strip_q && b == mtd_pkg::CHAR_CR) && step_q.size() < 3) begin
      step_q.push_back(decoded_t'{data: b, bad: bad, last: 1'b0});
    end
  endfunction

  function automatic int sextet_of(logic [7:0] c);
    for (int i = 0; i < 65; i++) begin
      if (B64_CHARS[i] == c) return i;
    end
    return int'(mtd_pkg::B64_OTHER);
  endfunction

  function automatic int hex_of(logic [7:0] c);
    for (int i = 0; i < 16; i++) begin
      if (HEX_CHARS[i] == c) return i;
    end
    return 16;
  endfunction

  function automatic void b64_flush(int n, logic [5:0] s3);
    logic [5:0] s0, s1, s2;
    s0 = sextets[17:12];
    s1 = sextets[11:6];
    s2 = sextets[5:0];
    push_byte({s0, s1[5:4]}, 1'b0);
    if (n >= 2) push_byte({s1[3:0], s2[5:2]}, 1'b0);
    if (n >= 3) push_byte({s2[1:0], s3}, 1'b0);
    grp_cnt = 2'd0;
    sextets = 18'd0;
  endfunction

  function automatic void b64_step(logic [7:0] c);
    int v;
    v = sextet_of(c);
    if (v == int'(mtd_pkg::B64_OTHER)) return;
    if (v == int'(mtd_pkg::B64_PAD)) begin
      if (grp_cnt != 2'd0) b64_flush((grp_cnt == 2'd3) ? 2 : 1, 6'd0);
      return;
    end
    if (grp_cnt == 2'd3) begin
      b64_flush(3, v[5:0]);
    end else begin
      sextets[6 * (2 - int'(grp_cnt)) +: 6] = v[5:0];
      grp_cnt = grp_cnt + 2'd1;
    end
  endfunction

  function automatic void qp_step(logic [7:0] c);
    int h;
    case (esc)
      ESC_AFTER_EQ: begin
        if (c == mtd_pkg::CHAR_CR) begin
          esc = ESC_SOFT_CR;
        end else if (c == mtd_pkg::CHAR_LF) begin
          esc = ESC_NONE;
        end else begin
          h = hex_of(c);
          nib_bad = (h > 15);
          hi_nib = (h > 15) ? 4'd0 : h[3:0];
          esc = ESC_AFTER_DIGIT;
        end
      end
      ESC_AFTER_DIGIT: begin
        h = hex_of(c);
        if (h > 15) begin
          nib_bad = 1'b1;
          h = 0;
        end
        push_byte({hi_nib, h[3:0]}, nib_bad);
        esc = ESC_NONE;
        hi_nib = 4'd0;
        nib_bad = 1'b0;
      end
      ESC_SOFT_CR: begin
        esc = ESC_NONE;
      end
      default: begin
        if (c == mtd_pkg::CHAR_EQ) esc = ESC_AFTER_EQ;
        else push_byte(c, 1'b0);
      end
    endcase
  endfunction

  function automatic void decode_request(logic [7:0] c, logic eod);
    decoded_t tail;
    step_q.delete();
    case (mode_q)
      mtd_pkg::MODE_B64: begin
        b64_step(c);
        if (eod && grp_cnt != 2'd0) b64_flush((grp_cnt == 2'd3) ? 2 : 1, 6'd0);
      end
      mtd_pkg::MODE_QP: begin
        qp_step(c);
        if (eod && esc == ESC_AFTER_DIGIT) push_byte({hi_nib, 4'h0}, 1'b1);
      end
      default: begin
        push_byte(c, 1'b0);
      end
    endcase
    if (eod) clear_state();
    if (step_q.size() != 0) begin
      tail = step_q.pop_back();
      tail.last = 1'b1;
      step_q.push_back(tail);
    end
    foreach (step_q[i]) expected_q.push_back(step_q[i]);
  endfunction

  always @(posedge clk) begin
    if (gaps_on && ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      ready_hold <= $urandom_range(0, 16);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(negedge clk) begin
    decoded_t exp_item;
    if (out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected decoded byte: expected none, got data %02h bad %0b last %0b",
                 $time, out_tdata, out_tuser, out_tlast);
      end else begin
        exp_item = expected_q.pop_front();
        if (out_tdata !== exp_item.data || out_tuser !== exp_item.bad ||
            out_tlast !== exp_item.last) begin
          errors++;
          $display("%0t: decoded byte mismatch: expected data %02h bad %0b last %0b, %s",
                   $time, exp_item.data, exp_item.bad, exp_item.last,
                   $sformatf("got data %02h bad %0b last %0b",
                             out_tdata, out_tuser, out_tlast));
        end
      end
    end
  end

  always @(negedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eod);
    logic rdy;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= eod;
    do begin
      @(negedge clk);
      rdy = in_tready;
      if (rdy) decode_request(b, eod);
      @(posedge clk);
    end while (!rdy);
    sent_count++;
  endtask

  task automatic send_text(input string s, input logic eod_at_end);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], eod_at_end && (i == s.len() - 1));
    end
  endtask

  task automatic send_random_end(input logic [7:0] b);
    send_byte(b, $urandom_range(0, 13) == 0);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic idx, input logic [1:0] val);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == mtd_pkg::CFG_DECODE_MODE) begin
      mode_q = val;
      clear_state();
    end else begin
      strip_q = val[0];
    end
    @(posedge clk);
  endtask

  task automatic test_pass_through();
    configure(mtd_pkg::CFG_DECODE_MODE, mtd_pkg::MODE_PASS);
    configure(mtd_pkg::CFG_STRIP_CR, 2'd0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_strip_cr();
    configure(mtd_pkg::CFG_STRIP_CR, 2'd1);
    send_byte(mtd_pkg::CHAR_CR, 1'b0);
    send_byte(mtd_pkg::CHAR_LF, 1'b1);
    configure(mtd_pkg::CFG_STRIP_CR, 2'd0);
  endtask

  task automatic test_unused_mode();
    configure(mtd_pkg::CFG_DECODE_MODE, MODE_UNUSED);
    send_byte(mtd_pkg::CHAR_EQ, 1'b1);
  endtask

  task automatic test_base64();
    configure(mtd_pkg::CFG_DECODE_MODE, mtd_pkg::MODE_B64);
    send_text("*TWFu", 1'b0);
    send_text("TQ==", 1'b0);
    send_text("TW", 1'b1);
  endtask

  task automatic test_mode_change();
    configure(mtd_pkg::CFG_DECODE_MODE, mtd_pkg::MODE_B64);
    send_text("T", 1'b0);
    configure(mtd_pkg::CFG_DECODE_MODE, mtd_pkg::MODE_B64);
    send_text("TWE=", 1'b0);
  endtask

  task automatic test_quoted_printable();
    configure(mtd_pkg::CFG_DECODE_MODE, mtd_pkg::MODE_QP);
    send_text("=4Z", 1'b0);
    send_byte(mtd_pkg::CHAR_EQ, 1'b0);
    send_byte(mtd_pkg::CHAR_CR, 1'b0);
    send_byte("X", 1'b0);
    send_text("=\n", 1'b0);
    send_text("=G", 1'b1);
    send_text("=", 1'b1);
  endtask

  task automatic run_random_phase(input logic [1:0] m, input logic s, input int n);
    int start;
    int r;
    configure(mtd_pkg::CFG_DECODE_MODE, m);
    configure(mtd_pkg::CFG_STRIP_CR, {1'b0, s});
    start = sent_count;
    while (sent_count - start < n) begin
      r = $urandom_range(0, 99);
      case (m)
        mtd_pkg::MODE_B64: begin
          if (r < 78) send_random_end(B64_CHARS[$urandom_range(0, 63)]);
          else if (r < 84) send_random_end(mtd_pkg::CHAR_EQ);
          else if (r < 92) send_random_end(8'($urandom_range(0, 255)));
          else send_random_end((r < 96) ? mtd_pkg::CHAR_CR : mtd_pkg::CHAR_LF);
        end
        mtd_pkg::MODE_QP: begin
          if (r < 50) begin
            send_random_end(8'($urandom_range(8'h20, 8'h7E)));
          end else if (r < 56) begin
            send_random_end((r < 53) ? mtd_pkg::CHAR_CR : mtd_pkg::CHAR_LF);
          end else if (r < 80) begin
            send_random_end(mtd_pkg::CHAR_EQ);
            send_random_end(HEX_CHARS[$urandom_range(0, 15)]);
            send_random_end(HEX_CHARS[$urandom_range(0, 15)]);
          end else if (r < 88) begin
            send_random_end(mtd_pkg::CHAR_EQ);
            if (r < 84) send_random_end(mtd_pkg::CHAR_CR);
            send_random_end(mtd_pkg::CHAR_LF);
          end else if (r < 94) begin
            send_random_end(mtd_pkg::CHAR_EQ);
            send_random_end(8'($urandom_range(0, 255)));
            send_random_end(8'($urandom_range(0, 255)));
          end else begin
            send_random_end(8'($urandom_range(0, 255)));
          end
        end
        default: begin
          send_random_end(8'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  task automatic test_random();
    logic [1:0] modes[6] = '{mtd_pkg::MODE_PASS, mtd_pkg::MODE_B64, mtd_pkg::MODE_QP,
                             MODE_UNUSED, mtd_pkg::MODE_B64, mtd_pkg::MODE_QP};
    logic       strips[6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    for (int i = 0; i < 6; i++) run_random_phase(modes[i], strips[i], 26);
    for (int i = 0; i < 2; i++) begin
      run_random_phase(2'($urandom_range(1, 2)), 1'($urandom_range(0, 1)), 26);
    end
    drain();
    gaps_on = 1'b0;
    run_random_phase(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 26);
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_pass_through();
    test_strip_cr();
    test_unused_mode();
    test_base64();
    test_mode_change();
    test_quoted_printable();
    test_random();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
